[rtl/core/wcgd_pkg.sv]
// Shared types, constants and elaboration-time kernel functions for the rate filter.
package wcgd_pkg;

	localparam int DIG = 4;
	localparam int SAMPLE_W = 8;
	localparam int RATE_W = 48;
	localparam int WRAP_STEP = 256;

	localparam logic signed [63:0] RATE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] RATE_MIN = -RATE_MAX - 64'sd1;

	localparam logic [63:0] QONE = 64'd1 << 31;
	localparam logic [63:0] QHALF = 64'd1 << 30;
	localparam logic [63:0] INV_E_Q31 = 64'd790015084;
	localparam logic [63:0] INV_SQRT_2PI_Q31 = 64'd856722024;
	localparam logic [63:0] MS_PER_S = 64'd1000;
	localparam int TAYLOR_TERMS = 24;

	typedef struct packed {
		logic clear;
		logic load;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic last;
	} mac_sts_t;

	// restoring shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], a[k]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f) in Q31 from the alternating Taylor series
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic signed [63:0] sum;
		logic [63:0] term;
		logic stop;
		sum = $signed(QONE);
		term = QONE;
		stop = 1'b0;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			if (!stop) begin
				term = udiv((term * f) >> 31, 64'(k));
				if (term == 64'd0) begin
					stop = 1'b1;
				end else if (k % 2 == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
		end
		return (sum < 0) ? 64'd0 : $unsigned(sum);
	endfunction

	function automatic logic signed [63:0] kern_word(input int taps, input int sigma,
			input int period, input int frac, input int i);
		logic [63:0] s2, den8, dd, ad, d2, n, r, g, h, mag;
		logic signed [63:0] d;
		s2 = 64'(sigma) * 64'(sigma);
		den8 = 64'd8 * s2;
		dd = (64'd1 << (32 - frac)) * 64'(period) * s2 * 64'(sigma);
		d = 64'(2 * i - (taps - 1));
		ad = (d < 0) ? $unsigned(-d) : $unsigned(d);
		if (ad == 64'd0) begin
			return 64'sd0;
		end
		d2 = ad * ad;
		n = udiv(d2, den8);
		r = d2 - n * den8;
		g = exp_neg_frac(udiv(r << 31, den8));
		for (logic [63:0] j = 64'd0; j < n && g != 64'd0; j++) begin
			g = (g * INV_E_Q31 + QHALF) >> 31;
		end
		h = (g * INV_SQRT_2PI_Q31 + QHALF) >> 31;
		mag = udiv(h * ad * MS_PER_S + (dd >> 1), dd);
		return (d < 0) ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [63:0] kern_max(input int taps, input int sigma,
			input int period, input int frac);
		logic signed [63:0] w;
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < taps; i++) begin
			w = kern_word(taps, sigma, period, frac, i);
			if (w < 0) begin
				w = -w;
			end
			if ($unsigned(w) > m) begin
				m = $unsigned(w);
			end
		end
		return m;
	endfunction

endpackage

[rtl/core/wrapping_counter_gaussian_derivative_core.sv]
// Top level: derivative-of-Gaussian rate filter over an unwrapped 8-bit counter window.
// A sample beat gives one rate beat after the digit-serial multiply-accumulate has run over all
// TAPS taps, ND being the number of 4-bit digits of an unwrapped sample (4 at the defaults).
// A new beat is taken only when idle, once the last result has been loaded into the output register.
// A clear beat gives no result. Reset empties the window and head pointer;
// the kernel is a constant table, so no start-up pass is needed.
module wrapping_counter_gaussian_derivative_core #(
	parameter int TAPS = 21,
	parameter int SIGMA = 3,
	parameter int SAMPLE_PERIOD_MS = 100,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [wcgd_pkg::SAMPLE_W-1:0]       sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wcgd_pkg::RATE_W-1:0]  rate
);

	localparam int DIG = wcgd_pkg::DIG;
	localparam int PW = $clog2(TAPS);
	localparam int UW_MIN = $clog2(wcgd_pkg::WRAP_STEP * TAPS);
	localparam int ND = (UW_MIN + DIG - 1) / DIG;
	localparam int UW = ND * DIG;
	localparam logic [63:0] KMAX =
		wcgd_pkg::kern_max(TAPS, SIGMA, SAMPLE_PERIOD_MS, COEF_FRAC_BITS);
	localparam int KW = $clog2(KMAX + 64'd1) + 1;
	localparam int AWC = KW + UW + $clog2(TAPS) + 1;
	localparam int AW = (AWC > wcgd_pkg::RATE_W) ? AWC : wcgd_pkg::RATE_W + 1;
	localparam logic [PW-1:0] LAST_TAP = PW'(TAPS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_RUN   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                            state_q, state_d;
	logic [PW-1:0]                     head_q, head_nxt;
	logic [PW-1:0]                     rd_ptr_q, rd_ptr_nxt;
	logic [PW-1:0]                     tap_q;
	logic [wcgd_pkg::SAMPLE_W-1:0]     prev_q;
	logic [UW-1:0]                     offset_q, off_n, u_val;
	logic                              out_valid_q;
	logic signed [wcgd_pkg::RATE_W-1:0] rate_q;

	logic                              accept, win_clr, win_wr, win_rd, out_load, wrap;
	logic [wcgd_pkg::SAMPLE_W-1:0]     rd_data;
	logic signed [KW-1:0]              kern_tab [TAPS];
	wcgd_pkg::mac_ctl_t                mac_ctl;
	wcgd_pkg::mac_sts_t                mac_sts;
	logic signed [wcgd_pkg::RATE_W-1:0] rate_sat;

	for (genvar g = 0; g < TAPS; g++) begin : g_kern
		localparam logic signed [KW-1:0] KWORD =
			KW'(wcgd_pkg::kern_word(TAPS, SIGMA, SAMPLE_PERIOD_MS, COEF_FRAC_BITS, g));
		assign kern_tab[g] = KWORD;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign head_nxt = (head_q == LAST_TAP) ? '0 : head_q + PW'(1);
	assign rd_ptr_nxt = (rd_ptr_q == LAST_TAP) ? '0 : rd_ptr_q + PW'(1);

	// unwrap: add one counter period each time the sequence steps down
	assign wrap = (tap_q != '0) && (prev_q > rd_data);
	assign off_n = wrap ? offset_q + UW'(wcgd_pkg::WRAP_STEP) : offset_q;
	assign u_val = off_n + UW'(rd_data);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		win_clr = 1'b0;
		win_wr = 1'b0;
		win_rd = 1'b0;
		mac_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action) begin
						win_clr = 1'b1;
					end else begin
						win_wr = 1'b1;
						mac_ctl.clear = 1'b1;
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				win_rd = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				mac_ctl.load = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (mac_sts.last) begin
					if (tap_q == LAST_TAP) begin
						state_d = ST_DONE;
					end else begin
						win_rd = 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			rd_ptr_q <= '0;
			tap_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (win_clr) begin
				head_q <= '0;
			end else if (win_wr) begin
				// new head is also the oldest entry
				head_q <= head_nxt;
				rd_ptr_q <= head_nxt;
				tap_q <= '0;
			end
			if (win_rd) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (state_q == ST_RUN && mac_sts.last && tap_q != LAST_TAP) begin
				tap_q <= tap_q + PW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_wr) begin
			offset_q <= '0;
		end else if (state_q == ST_LOAD) begin
			offset_q <= off_n;
			prev_q <= rd_data;
		end
		if (out_load) begin
			rate_q <= rate_sat;
		end
	end

	wcgd_window #(
		.TAPS (TAPS),
		.PW   (PW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (win_clr),
		.wr_en   (win_wr),
		.wr_addr (head_q),
		.wr_data (sample),
		.rd_en   (win_rd),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	wcgd_mac #(
		.KW (KW),
		.UW (UW),
		.ND (ND),
		.AW (AW)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.u_in     (u_val),
		.kern     (kern_tab[tap_q]),
		.sts      (mac_sts),
		.rate_sat (rate_sat)
	);

	assign out_valid = out_valid_q;
	assign rate = rate_q;

	a_idle_mac_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mac_sts.busy)
		else $error("multiply-accumulate busy while taking a new beat");

	a_last_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mac_sts.last |-> (state_q == ST_RUN))
		else $error("digit sequence ended outside the run state");

	a_done_all_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (tap_q == LAST_TAP))
		else $error("result finished before the last tap");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");

endmodule

[rtl/core/wcgd_window.sv]
// Sample window store: one write and one registered read per cycle, per-entry valid bits.
module wcgd_window #(
	parameter int TAPS = 21,
	parameter int PW = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic                           wr_en,
	input  logic [PW-1:0]                  wr_addr,
	input  logic [wcgd_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic                           rd_en,
	input  logic [PW-1:0]                  rd_addr,
	output logic [wcgd_pkg::SAMPLE_W-1:0]  rd_data
);

	logic [wcgd_pkg::SAMPLE_W-1:0] mem [TAPS];
	logic [TAPS-1:0]               valid_q;
	logic [wcgd_pkg::SAMPLE_W-1:0] mem_rd_q;
	logic                          vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= valid_q[rd_addr];
			end
		end
	end

	// an entry never written since the last clear reads as zero
	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule

[rtl/core/wcgd_mac.sv]
// Digit-serial multiply-accumulate: one unsigned digit of the sample times the kernel word a cycle.
module wcgd_mac #(
	parameter int KW = 20,
	parameter int UW = 16,
	parameter int ND = 4,
	parameter int AW = 49
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wcgd_pkg::mac_ctl_t                  ctl,
	input  logic [UW-1:0]                       u_in,
	input  logic signed [KW-1:0]                kern,
	output wcgd_pkg::mac_sts_t                  sts,
	output logic signed [wcgd_pkg::RATE_W-1:0]  rate_sat
);

	localparam int DIG = wcgd_pkg::DIG;
	localparam int DW = $clog2(ND);
	localparam int SW = KW + UW - DIG;
	localparam int PPW = SW + DIG + 1;
	localparam logic signed [AW-1:0] SAT_HI = AW'(wcgd_pkg::RATE_MAX);
	localparam logic signed [AW-1:0] SAT_LO = AW'(wcgd_pkg::RATE_MIN);

	logic signed [SW-1:0]  kern_sh_q;
	logic [UW-1:0]         dig_sr_q;
	logic [DW-1:0]         dig_q;
	logic                  busy_q;
	logic signed [AW-1:0]  acc_q;
	logic signed [PPW-1:0] pp;
	logic                  last;

	assign pp = kern_sh_q * $signed({1'b0, dig_sr_q[DIG-1:0]});
	assign last = busy_q && (dig_q == DW'(ND - 1));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kern_sh_q <= SW'(kern);
			dig_sr_q <= u_in;
		end else if (busy_q) begin
			// move the kernel up one digit as the sample moves down one
			kern_sh_q <= kern_sh_q <<< DIG;
			dig_sr_q <= dig_sr_q >> DIG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dig_q <= '0;
			acc_q <= '0;
		end else begin
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (busy_q) begin
				acc_q <= acc_q + AW'(pp);
			end
			if (ctl.load) begin
				busy_q <= 1'b1;
				dig_q <= '0;
			end else if (busy_q) begin
				dig_q <= dig_q + DW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		priority if (acc_q > SAT_HI) begin
			rate_sat = wcgd_pkg::RATE_W'(wcgd_pkg::RATE_MAX);
		end else if (acc_q < SAT_LO) begin
			rate_sat = wcgd_pkg::RATE_W'(wcgd_pkg::RATE_MIN);
		end else begin
			rate_sat = acc_q[wcgd_pkg::RATE_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.last = last;

endmodule
